FILE: rtl/tlpt_pkg.sv
// Package for the two-level page table engine: request/result types, codes,
// constants and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package tlpt_pkg;

    localparam int DIR_ENTRIES_DEF   = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int PAGE_BYTES_DEF    = 4096;

    localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;
    localparam logic [11:0] OFS_MASK   = 12'hFFF;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_WRITE   = 1;
    localparam int BIT_USER    = 2;

    typedef enum logic [1:0] {
        REQ_MAP       = 2'd0,
        REQ_UNMAP     = 2'd1,
        REQ_TRANSLATE = 2'd2,
        REQ_NONE      = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFRAME  = 2'd1,
        ST_USERKERN = 2'd2,
        ST_UNMAPPED = 2'd3
    } status_code_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic [11:0] map_flags;
        logic [19:0] spare_frame;
        logic        spare_valid;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] phys_out;
        logic        frame_taken;
        logic        table_freed;
        logic [19:0] freed_frame;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR_RD,
        S_DECIDE,
        S_ZERO,
        S_TBL_RD,
        S_TBL_CHK,
        S_SCAN,
        S_SCAN_CHK,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;    // capture the accepted request
        logic clr_dir;     // write zero to directory at the sweep counter
        logic dir_new;     // write new directory entry for the request slot
        logic dir_zero;    // clear the request slot's directory entry
        logic tbl_zero;    // write zero at the sweep counter in the slot's table
        logic tbl_map;     // write the mapped entry
        logic tbl_unmap;   // clear the request's table entry
        logic scan_rd;     // read the table entry at the sweep counter
        logic cnt_clr;     // reset the sweep counter
        logic cnt_inc;     // step the sweep counter
        logic set_result;  // latch result fields
        logic [1:0] res_status;
        logic res_taken;
        logic res_freed;
        logic res_phys;    // result carries the translated address
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_code_t req;
        logic pde_present;
        logic pde_user;
        logic want_user;
        logic spare_valid;
        logic entry_present;
        logic cnt_last;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/two_level_page_table_engine.sv
// Top level of the two-level page table engine: controller plus datapath.
// Depends on tlpt_pkg, tlpt_ctrl, tlpt_datapath and tlpt_ram.
//
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_req  (req_t: map, unmap, translate)
// m_        out        m_valid / m_ready   m_rsp  (rsp_t: status, address, frame info)
//
// After reset the directory is swept clear, one entry a cycle, and no request is
// accepted until that finishes. A request settled by the registered directory read
// alone (a failure, or a map into a present table) has its result latched in
// S_DECIDE; a translate or an unmap needs the dependent table read as well. A map
// that builds a new table first zeroes the whole table; an unmap of a user page
// also scans the table one entry at a time to see whether it can be freed.
// One request is worked on at a time; the next is taken once the result
// register is free or being drained, so a stalled m_ready holds the engine.
`default_nettype none
module two_level_page_table_engine
    import tlpt_pkg::*;
#(
    parameter int DIR_ENTRIES   = DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_req,
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_rsp
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The datapath's sweep counter is shared by the directory clear and the
    // table sweeps; the user must keep both sizes equal, which is not enforced.
    tlpt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    tlpt_datapath #(
        .DIR_ENTRIES(DIR_ENTRIES), .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .aclk(aclk), .req_in(s_req), .cmd(cmd), .stat(stat), .rsp(m_rsp)
    );
endmodule
`default_nettype wire

FILE: rtl/tlpt_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies.
`default_nettype none
module tlpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/tlpt_datapath.sv
// Datapath: request register, directory and table memories, sweep counter and result.
// Depends on tlpt_pkg and tlpt_ram.
`default_nettype none
module tlpt_datapath
    import tlpt_pkg::*;
#(
    parameter int DIR_ENTRIES   = DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic     aclk,
    input  wire req_t     req_in,
    input  wire dp_cmd_t  cmd,
    output dp_stat_t      stat,
    output rsp_t          rsp
);
    localparam int DW = $clog2(DIR_ENTRIES);
    localparam int TW = $clog2(TABLE_ENTRIES);

    req_t          req_reg;
    logic [TW-1:0] cnt_reg;
    rsp_t          rsp_reg;

    logic [DW-1:0]    dir_idx;
    logic [TW-1:0]    tbl_idx;
    logic [DW-1:0]    dir_addr;
    logic             dir_we;
    logic [31:0]      dir_wdata, pde;
    logic [DW+TW-1:0] tbl_addr;
    logic             tbl_we;
    logic [31:0]      tbl_wdata, pte;
    logic [31:0]      map_entry;

    assign dir_idx   = req_reg.virt_addr[22 +: DW];
    assign tbl_idx   = req_reg.virt_addr[12 +: TW];
    assign map_entry = req_reg.phys_addr | {20'd0, req_reg.map_flags};

    always_comb begin
        dir_addr  = cmd.clr_dir ? cnt_reg[DW-1:0] : dir_idx;
        dir_we    = cmd.clr_dir | cmd.dir_new | cmd.dir_zero;
        dir_wdata = '0;
        if (cmd.dir_new) begin
            dir_wdata = {req_reg.spare_frame, 12'd0};
            dir_wdata[BIT_WRITE]   = 1'b1;
            dir_wdata[BIT_PRESENT] = 1'b1;
            dir_wdata[BIT_USER]    = req_reg.map_flags[BIT_USER];
        end
        if (cmd.tbl_zero || cmd.scan_rd) begin
            tbl_addr = {dir_idx, cnt_reg};
        end else begin
            tbl_addr = {dir_idx, tbl_idx};
        end
        tbl_we    = cmd.tbl_zero | cmd.tbl_map | cmd.tbl_unmap;
        tbl_wdata = cmd.tbl_map ? map_entry : 32'd0;
    end

    tlpt_ram #(.WIDTH(32), .DEPTH(DIR_ENTRIES)) u_dir (
        .aclk(aclk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(pde)
    );

    tlpt_ram #(.WIDTH(32), .DEPTH(DIR_ENTRIES * TABLE_ENTRIES)) u_tbl (
        .aclk(aclk), .we(tbl_we), .addr(tbl_addr), .wdata(tbl_wdata), .rdata(pte)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req_in;
        end
        if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + TW'(1);
        end
        if (cmd.set_result) begin
            rsp_reg.status      <= cmd.res_status;
            rsp_reg.frame_taken <= cmd.res_taken;
            rsp_reg.table_freed <= cmd.res_freed;
            rsp_reg.freed_frame <= cmd.res_freed ? pde[31:12] : 20'd0;
            rsp_reg.phys_out    <= cmd.res_phys ?
                                   ((pte & FRAME_MASK) | {20'd0, req_reg.virt_addr[11:0]}) :
                                   32'd0;
        end
    end

    // One sweep counter serves the directory clear and the table sweeps, so both
    // sizes must match.
    assign stat.req           = req_code_t'(req_reg.req_type);
    assign stat.pde_present   = pde[BIT_PRESENT];
    assign stat.pde_user      = pde[BIT_USER];
    assign stat.want_user     = req_reg.map_flags[BIT_USER];
    assign stat.spare_valid   = req_reg.spare_valid;
    assign stat.entry_present = pte[BIT_PRESENT];
    assign stat.cnt_last      = (cnt_reg == TW'(TABLE_ENTRIES - 1));
    assign rsp = rsp_reg;
endmodule
`default_nettype wire

FILE: rtl/tlpt_ctrl.sv
// Controller state machine: sequences clears, reads, scans and the handshakes.
// Depends on tlpt_pkg.
`default_nettype none
module tlpt_ctrl
    import tlpt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_dir = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    cmd.cnt_inc = 1'b0;
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DIR_RD;
                end
            end
            S_DIR_RD: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.cnt_clr = 1'b1;
                unique case (stat.req) inside
                    REQ_MAP: begin
                        if (!stat.pde_present) begin
                            if (!stat.spare_valid) begin
                                cmd.res_status = ST_NOFRAME;
                                state_next     = S_DONE;
                            end else begin
                                cmd.dir_new = 1'b1;
                                state_next  = S_ZERO;
                            end
                        end else if (stat.want_user && !stat.pde_user) begin
                            cmd.res_status = ST_USERKERN;
                            state_next     = S_DONE;
                        end else begin
                            cmd.tbl_map = 1'b1;
                            cmd.res_status = ST_OK;
                            state_next  = S_DONE;
                        end
                        cmd.set_result = (state_next == S_DONE);
                    end
                    REQ_UNMAP, REQ_TRANSLATE: begin
                        if (!stat.pde_present) begin
                            cmd.res_status = ST_UNMAPPED;
                            cmd.set_result = 1'b1;
                            state_next     = S_DONE;
                        end else begin
                            state_next = S_TBL_RD;
                        end
                    end
                    default: begin
                        cmd.res_status = ST_UNMAPPED;
                        cmd.set_result = 1'b1;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_ZERO: begin
                // Only the table is touched here; the directory read is not used.
                cmd.tbl_zero = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_last) begin
                    state_next = S_TBL_CHK;
                end
            end
            S_TBL_RD: begin
                state_next = S_TBL_CHK;
            end
            S_TBL_CHK: begin
                cmd.set_result = 1'b1;
                cmd.cnt_clr    = 1'b1;
                if (stat.req == REQ_MAP) begin
                    cmd.tbl_map    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_taken  = 1'b1;
                    state_next     = S_DONE;
                end else if (!stat.entry_present) begin
                    cmd.res_status = ST_UNMAPPED;
                    state_next     = S_DONE;
                end else if (stat.req == REQ_TRANSLATE) begin
                    cmd.res_status = ST_OK;
                    cmd.res_phys   = 1'b1;
                    state_next     = S_DONE;
                end else begin
                    cmd.tbl_unmap  = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.set_result = !stat.pde_user;
                    state_next     = stat.pde_user ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (stat.entry_present) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_DONE;
                end else if (stat.cnt_last) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_freed  = 1'b1;
                    cmd.dir_zero   = 1'b1;
                    state_next     = S_DONE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_DONE: begin
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // Hold the sweep counter at zero during reset so the directory clear
        // starts at the first entry.
        if (!aresetn) begin
            cmd         = '0;
            cmd.cnt_clr = 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("request accepted outside idle");
    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> m_valid)
        else $error("result not presented after done");
    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DIR_RD))
        else $error("accepted request did not start a walk");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> (!m_valid || m_ready))
        else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire
